/* design/cof_pkg.sv */
// ----------------------------------------------------------------------------
// cof_pkg: shared types and constants for the console output formatter
// Command format between the front and back parts, character codes, and
// the default tab stop.
// ----------------------------------------------------------------------------
package cof_pkg;

    localparam int TAB_STOP_DEFAULT = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // what the back part does with one request
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_CARET = 2'd1,
        KIND_TAB   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
    } cmd_t;

    // queue status toward producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* design/console_output_formatter_core.sv */
// ----------------------------------------------------------------------------
// console_output_formatter_core: console byte formatter
// Tab expansion, caret notation for control characters, column tracking.
// ----------------------------------------------------------------------------
// Each input request carries one character (tdata) and a caret-mode flag
// (tuser). A tab becomes spaces up to the next multiple of TAB_STOP columns
// (at least one space; a column wrap past 255 to 0 counts as a stop). With
// caret mode set, a control character below 0x20 other than tab becomes
// '^' and the character plus 0x40. As a plain byte, CR zeroes the column, BS
// lowers it if not zero, LF leaves it; every other output byte advances it
// modulo 256. The final output byte of each request has tlast high. Timing:
// the emitter produces one output byte per cycle while its output register is
// free; it loads each command from the queue in its idle state, then emits one
// byte for a plain char, two for a caret pair, up to TAB_STOP for a tab. The
// emitter is the pace setter; the front takes new requests while the two-entry
// queue has room. The emitter has a single output register, so it stalls
// while a byte waits on m_axis_tready and resumes in the cycle it is taken.
// ----------------------------------------------------------------------------
module console_output_formatter_core #(
    parameter int TAB_STOP = cof_pkg::TAB_STOP_DEFAULT   // 2..64
) (
    input  logic       aclk,
    input  logic       aresetn,
    // request side
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] char_in
    input  logic       s_axis_tuser,    // [0] caret_mode
    // display byte side
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] char_out
    output logic       m_axis_tlast     // last byte for this request
);
    import cof_pkg::*;

    queue_status_t q_status;
    logic          push, pop;
    cmd_t          push_cmd, pop_cmd;

    // classify requests into commands
    cof_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // command queue between intake and emitter
    cof_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // emit bytes, own the column
    cof_back #(
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_cmd       (pop_cmd),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* design/cof_front.sv */
// ----------------------------------------------------------------------------
// cof_front: request intake and classification
// Accepts one character request per handshake and turns it into a command
// (plain byte, caret pair or tab expansion) for the queue.
// ----------------------------------------------------------------------------
module cof_front (
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] char_in
    input  logic                   s_axis_tuser,   // [0] caret_mode
    input  cof_pkg::queue_status_t q_status,
    output logic                   push,
    output cof_pkg::cmd_t          push_cmd
);
    import cof_pkg::*;

    logic is_ctrl;

    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && !q_status.full;

    // control range is below space; tab is never shown as a caret pair
    assign is_ctrl = (s_axis_tdata < CH_SPACE) && (s_axis_tdata != CH_TAB);

    always_comb begin
        push_cmd.char_code = s_axis_tdata;
        if (s_axis_tdata == CH_TAB) begin
            push_cmd.kind = KIND_TAB;
        end else if (s_axis_tuser && is_ctrl) begin
            push_cmd.kind = KIND_CARET;
        end else begin
            push_cmd.kind = KIND_PLAIN;
        end
    end

endmodule

/* design/cof_queue.sv */
// ----------------------------------------------------------------------------
// cof_queue: short command queue
// Small FIFO that decouples request intake from byte emission.
// ----------------------------------------------------------------------------
module cof_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cof_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output cof_pkg::cmd_t          pop_cmd,
    output cof_pkg::queue_status_t status
);
    import cof_pkg::*;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/cof_back.sv */
// ----------------------------------------------------------------------------
// cof_back: byte emitter
// Executes queued commands one output byte per cycle unless the output stalls,
// tracks the screen column and its tab-stop phase, drives the output register.
// ----------------------------------------------------------------------------
module cof_back #(
    parameter int TAB_STOP = cof_pkg::TAB_STOP_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cof_pkg::cmd_t          pop_cmd,
    input  cof_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] char_out
    output logic                   m_axis_tlast    // last
);
    import cof_pkg::*;

    localparam int PHASE_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'(TAB_STOP - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        MV_INC,
        MV_DEC,
        MV_ZERO,
        MV_HOLD
    } move_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic               second_reg, second_next;
    logic [7:0]         column_reg, column_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               tvalid_reg, tvalid_next;
    logic [7:0]         tdata_reg, tdata_next;
    logic               tlast_reg, tlast_next;

    logic               out_free;
    logic [7:0]         byte_out;
    logic               byte_last;
    move_t              move;
    logic [PHASE_W-1:0] phase_inc;

    assign out_free      = !tvalid_reg || m_axis_tready;
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;
    assign pop           = (state_reg == ST_IDLE) && !q_status.empty;

    // phase = column mod TAB_STOP; a wrap of the column to 0 is a tab stop
    assign phase_inc = (column_reg == 8'hFF || phase_reg == PHASE_MAX) ? '0
                                                                       : phase_reg + 1'b1;

    // byte and column move for the current step of the command
    always_comb begin
        byte_out  = cmd_reg.char_code;
        byte_last = 1'b1;
        move      = MV_INC;
        case (cmd_reg.kind)
            KIND_TAB: begin
                byte_out  = CH_SPACE;
                byte_last = (phase_inc == '0);
            end
            KIND_CARET: begin
                byte_out  = second_reg ? (cmd_reg.char_code + CH_AT) : CH_CARET;
                byte_last = second_reg;
            end
            default: begin
                if (cmd_reg.char_code == CH_CR) begin
                    move = MV_ZERO;
                end else if (cmd_reg.char_code == CH_BS) begin
                    move = MV_DEC;
                end else if (cmd_reg.char_code == CH_LF) begin
                    move = MV_HOLD;
                end
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        second_next = second_reg;
        column_next = column_reg;
        phase_next  = phase_reg;
        tvalid_next = tvalid_reg && !m_axis_tready;
        tdata_next  = tdata_reg;
        tlast_next  = tlast_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    cmd_next    = pop_cmd;
                    second_next = 1'b0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    tvalid_next = 1'b1;
                    tdata_next  = byte_out;
                    tlast_next  = byte_last;
                    second_next = 1'b1;
                    case (move)
                        MV_INC: begin
                            column_next = column_reg + 8'd1;
                            phase_next  = phase_inc;
                        end
                        MV_DEC: begin
                            if (column_reg != 8'd0) begin
                                column_next = column_reg - 8'd1;
                                phase_next  = (phase_reg == '0) ? PHASE_MAX
                                                                : phase_reg - 1'b1;
                            end
                        end
                        MV_ZERO: begin
                            column_next = 8'd0;
                            phase_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (byte_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
            column_reg <= 8'd0;
            phase_reg  <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            column_reg <= column_next;
            phase_reg  <= phase_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

endmodule
